>>> rtl/core/adv_pkg.sv
// ----------------------------------------------------------------------------
// adv_pkg
// Shared constants for the upwind advection stencil block: field widths,
// config defaults, command codes, fixed-point constants and saturation limits.
// ----------------------------------------------------------------------------
package adv_pkg;

    // Grid geometry and sample format
    localparam int MAX_POINTS  = 1024;
    localparam int SAMPLE_W    = 16;
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = INDEX_W + 1;
    localparam int CFL_W       = 16;
    localparam int WEIGHT_W    = 20;

    // Configuration register indexes
    localparam logic CFG_CFL       = 1'b0;
    localparam logic CFG_GRID_LAST = 1'b1;

    localparam logic [CFL_W-1:0]   CFL_RESET       = 16'd16384;
    localparam logic [INDEX_W-1:0] GRID_LAST_RESET = 10'd1023;
    localparam logic [INDEX_W-1:0] GRID_LAST_MIN   = 10'd3;

    // Command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Weight arithmetic: one in Q1.15, half of the 6*2^29 divisor,
    // and 2^25/3 rounded up for the divide by three
    localparam logic signed [17:0] UNIT_Q15 = 18'sd32768;
    localparam logic signed [17:0] TWO_Q15  = 18'sd65536;
    localparam logic [53:0]        HALF_DEN = 54'd1610612736;
    localparam logic [23:0]        RECIP_3  = 24'd11184811;

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 20'sd524287;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = -20'sd524288;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;

endpackage

>>> rtl/core/advection_stencil_step.sv
// ----------------------------------------------------------------------------
// advection_stencil_step
// Grid of signed Q4.12 samples in one synchronous memory, advanced in place
// by the third-order four-point upwind advection stencil.
//
// Input channel (in_valid / in_stall) carries command, point_index and
// sample_in; a transfer happens when in_valid is high and in_stall is low.
// A write stores sample_in at point_index in its transfer cycle. A read
// issues a memory read in its transfer cycle; the sample lands in the memory
// output register, moves on to the output register when that is free, and is
// offered on out_valid / out_stall with point_out. Reads and writes sustain
// one transfer per cycle. If the receiver stalls, the read data is held in
// the memory output register, and further transfers stall until the output
// register frees up. A step first derives the four weight numerators from
// cfl on a shared 36x18 multiplier, divides them by 6*2^29 with a reciprocal
// multiply, one weight per cycle, then streams the grid once through the
// memory, one point per cycle, through a four-sample window and a
// multiply/add/round pipeline, and finishes with two boundary writes. The
// input is stalled for the whole step.
// Reset clears control state and sets cfl and grid_last to their defaults;
// grid contents are undefined until written.
// ----------------------------------------------------------------------------
module advection_stencil_step (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [adv_pkg::CFL_W-1:0]           cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          command,
    input  logic [adv_pkg::INDEX_W-1:0]         point_index,
    input  logic signed [adv_pkg::SAMPLE_W-1:0] sample_in,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [adv_pkg::INDEX_W-1:0]         point_out,
    output logic signed [adv_pkg::SAMPLE_W-1:0] sample_out
);
    import adv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WMUL,
        S_WDIV,
        S_RUN,
        S_FIX0,
        S_FIXL
    } state_t;

    state_t state_reg;

    // configuration
    logic [CFL_W-1:0]   cfl_reg;
    logic [INDEX_W-1:0] grid_last_reg;

    // control counters and valids
    logic [2:0]         wph_reg;
    logic [1:0]         wk_reg;
    logic [COUNT_W-1:0] rd_cnt_reg;
    logic [COUNT_W-1:0] sh_cnt_reg;
    logic               rv_reg;
    logic               wv_reg;
    logic               mv_reg;
    logic               av_reg;
    logic               dv_reg;
    logic               pend_reg;
    logic [INDEX_W-1:0] pend_idx_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] point_out_reg;
    logic [SAMPLE_W-1:0] sample_out_reg;

    // weight datapath
    logic signed [35:0]         t1_reg, t2_reg, t3_reg;
    logic signed [53:0]         n_reg [4];
    logic [22:0]                dy_reg;
    logic                       dneg_reg;
    logic [1:0]                 dk_reg;
    logic signed [WEIGHT_W-1:0] weight_reg [4];

    // stencil datapath
    logic signed [SAMPLE_W-1:0] win_reg [4];
    logic [INDEX_W-1:0]         wi_reg, mi_reg, ai_reg;
    logic signed [35:0]         mp_reg [4];
    logic signed [37:0]         acc_reg;
    logic [SAMPLE_W-1:0]        fix1_reg, fixm_reg;

    // grid memory
    logic [SAMPLE_W-1:0] grid_mem [MAX_POINTS];
    logic [SAMPLE_W-1:0] mem_q;
    logic                mem_we, mem_re;
    logic [INDEX_W-1:0]  mem_waddr, mem_raddr;
    logic [SAMPLE_W-1:0] mem_wdata;

    // ---------------------------------------------------------------- handshake
    logic out_take, pend_move, in_fire;

    assign out_take  = !out_valid_reg || !out_stall;
    assign pend_move = pend_reg && out_take;
    assign in_stall  = (state_reg != S_IDLE) ||
                       (pend_reg && (!out_take || command == CMD_STEP));
    assign in_fire   = in_valid && !in_stall;

    assign out_valid  = out_valid_reg;
    assign point_out  = point_out_reg;
    assign sample_out = signed'(sample_out_reg);

    // ---------------------------------------------------------------- grid bounds
    logic [INDEX_W-1:0] last_idx, last_m1;
    logic [COUNT_W-1:0] rd_end, rd_cnt_m1;
    logic               run_rd;
    logic [INDEX_W-1:0] run_addr;

    assign last_idx  = (grid_last_reg < GRID_LAST_MIN) ? GRID_LAST_MIN : grid_last_reg;
    assign last_m1   = last_idx - INDEX_W'(1);
    assign rd_end    = {1'b0, last_idx} + COUNT_W'(2);
    assign rd_cnt_m1 = rd_cnt_reg - COUNT_W'(1);
    assign run_rd    = (state_reg == S_RUN) && (rd_cnt_reg != rd_end);
    // read order: last point, then 0 up to last
    assign run_addr  = (rd_cnt_reg == '0) ? last_idx : rd_cnt_m1[INDEX_W-1:0];

    // ---------------------------------------------------------------- weight multiplier
    logic signed [17:0] c_s, a_s, b_s, p_s;
    logic signed [35:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [53:0] mul_p;

    // a = 1-c, b = 2-c, p = 1+c, all in Q.15
    assign c_s = signed'({2'b00, cfl_reg});
    assign a_s = UNIT_Q15 - c_s;
    assign b_s = TWO_Q15 - c_s;
    assign p_s = UNIT_Q15 + c_s;

    always_comb
    begin
        mul_a = 36'(c_s);
        mul_b = a_s;
        unique case (wph_reg)
            3'd0:    begin mul_a = 36'(c_s); mul_b = a_s; end
            3'd1:    begin mul_a = 36'(c_s); mul_b = b_s; end
            3'd2:    begin mul_a = 36'(a_s); mul_b = b_s; end
            3'd3:    begin mul_a = t1_reg;   mul_b = b_s; end
            3'd4:    begin mul_a = t1_reg;   mul_b = p_s; end
            3'd5:    begin mul_a = t2_reg;   mul_b = p_s; end
            3'd6:    begin mul_a = t3_reg;   mul_b = p_s; end
            default: begin mul_a = 36'(c_s); mul_b = a_s; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------------------------------------------------------- divide by 6*2^29
    logic signed [53:0]         n_sel, n_mag;
    logic                       n_neg;
    logic [53:0]                n_rnd;
    logic [46:0]                dq_prod;
    logic [21:0]                dq, dq_neg;
    logic signed [WEIGHT_W-1:0] w_sat;

    assign n_sel   = n_reg[wk_reg];
    assign n_neg   = n_sel[53];
    assign n_mag   = n_neg ? -n_sel : n_sel;
    // round half away from zero on the magnitude; x / (6*2^29) = (x >> 30) / 3
    assign n_rnd   = unsigned'(n_mag) + HALF_DEN;
    // divide by three: multiply by 2^25/3 rounded up, exact below 2^25
    assign dq_prod = dy_reg * RECIP_3;
    assign dq      = dq_prod[46:25];
    assign dq_neg  = -dq;

    // saturate the signed quotient to 20 bits
    always_comb
    begin
        if (dneg_reg)
        begin
            if (dq > 22'd524288)
                w_sat = WEIGHT_MIN;
            else
                w_sat = signed'(dq_neg[WEIGHT_W-1:0]);
        end
        else
        begin
            if (dq > 22'd524287)
                w_sat = WEIGHT_MAX;
            else
                w_sat = signed'(dq[WEIGHT_W-1:0]);
        end
    end

    // ---------------------------------------------------------------- stencil round
    logic signed [38:0]         acc_rnd;
    logic signed [22:0]         acc_sh;
    logic signed [SAMPLE_W-1:0] sat_sample;

    // round to nearest, ties up, then saturate
    assign acc_rnd = 39'(acc_reg) + 39'sd32768;
    assign acc_sh  = acc_rnd[38:16];

    always_comb
    begin
        if (acc_sh > 23'(SAMPLE_MAX))
            sat_sample = SAMPLE_MAX;
        else if (acc_sh < 23'(SAMPLE_MIN))
            sat_sample = SAMPLE_MIN;
        else
            sat_sample = acc_sh[SAMPLE_W-1:0];
    end

    // ---------------------------------------------------------------- memory port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = point_index;
        mem_wdata = sample_in;
        mem_re    = 1'b0;
        mem_raddr = point_index;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_we = in_fire && (command == CMD_WRITE);
                mem_re = in_fire && (command == CMD_READ);
            end
            S_RUN:
            begin
                mem_we    = av_reg;
                mem_waddr = ai_reg;
                mem_wdata = sat_sample;
                mem_re    = run_rd;
                mem_raddr = run_addr;
            end
            S_FIX0:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = fixm_reg;
            end
            S_FIXL:
            begin
                mem_we    = 1'b1;
                mem_waddr = last_idx;
                mem_wdata = fix1_reg;
            end
            default:
            begin
                mem_we = 1'b0;
                mem_re = 1'b0;
            end
        endcase
    end

    // grid memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= grid_mem[mem_raddr];
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfl_reg        <= CFL_RESET;
            grid_last_reg  <= GRID_LAST_RESET;
            wph_reg        <= '0;
            wk_reg         <= '0;
            rd_cnt_reg     <= '0;
            sh_cnt_reg     <= '0;
            rv_reg         <= 1'b0;
            wv_reg         <= 1'b0;
            mv_reg         <= 1'b0;
            av_reg         <= 1'b0;
            dv_reg         <= 1'b0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            point_out_reg  <= '0;
            sample_out_reg <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_CFL:       cfl_reg       <= cfg_data;
                    CFG_GRID_LAST: grid_last_reg <= cfg_data[INDEX_W-1:0];
                    default:       cfl_reg       <= cfl_reg;
                endcase
            end

            // read pending in the memory output register
            if (in_fire && command == CMD_READ)
            begin
                pend_reg     <= 1'b1;
                pend_idx_reg <= point_index;
            end
            else if (pend_move)
                pend_reg <= 1'b0;

            // output register
            if (pend_move)
            begin
                out_valid_reg  <= 1'b1;
                point_out_reg  <= pend_idx_reg;
                sample_out_reg <= mem_q;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // weight divide second stage follows each first-stage cycle
            dv_reg <= (state_reg == S_WDIV);

            // stencil pipeline valids
            rv_reg <= run_rd;
            if (run_rd)
                rd_cnt_reg <= rd_cnt_reg + COUNT_W'(1);
            if (rv_reg)
                sh_cnt_reg <= sh_cnt_reg + COUNT_W'(1);
            wv_reg <= rv_reg && (sh_cnt_reg >= COUNT_W'(3));
            mv_reg <= wv_reg;
            av_reg <= mv_reg;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && command == CMD_STEP)
                    begin
                        state_reg <= S_WMUL;
                        wph_reg   <= '0;
                    end
                end
                S_WMUL:
                begin
                    wph_reg <= wph_reg + 3'd1;
                    if (wph_reg == 3'd6)
                    begin
                        state_reg <= S_WDIV;
                        wk_reg    <= '0;
                    end
                end
                S_WDIV:
                begin
                    wk_reg <= wk_reg + 2'd1;
                    if (wk_reg == 2'd3)
                    begin
                        state_reg  <= S_RUN;
                        rd_cnt_reg <= '0;
                        sh_cnt_reg <= '0;
                    end
                end
                S_RUN:
                begin
                    if (av_reg && ai_reg == last_m1)
                        state_reg <= S_FIX0;
                end
                S_FIX0:
                    state_reg <= S_FIXL;
                S_FIXL:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------- weight datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WMUL)
        begin
            unique case (wph_reg)
                3'd0:    t1_reg   <= mul_p[35:0];
                3'd1:    t2_reg   <= mul_p[35:0];
                3'd2:    t3_reg   <= mul_p[35:0];
                3'd3:    n_reg[0] <= -mul_p;
                3'd4:    n_reg[3] <= -mul_p;
                3'd5:    n_reg[2] <= mul_p + (mul_p <<< 1);
                3'd6:    n_reg[1] <= mul_p + (mul_p <<< 1);
                default: t1_reg   <= t1_reg;
            endcase
        end

        // first stage: rounded magnitude over 2^30 and its sign
        if (state_reg == S_WDIV)
        begin
            dy_reg   <= n_rnd[52:30];
            dneg_reg <= n_neg;
            dk_reg   <= wk_reg;
        end

        // second stage: saturated quotient into the weight
        if (dv_reg)
            weight_reg[dk_reg] <= w_sat;
    end

    // ---------------------------------------------------------------- stencil datapath
    always_ff @(posedge clk)
    begin
        // window: entry 0 is u[i+1], entry 3 is u[i-2]
        if (rv_reg)
        begin
            win_reg[0] <= signed'(mem_q);
            win_reg[1] <= win_reg[0];
            win_reg[2] <= win_reg[1];
            win_reg[3] <= win_reg[2];
            wi_reg     <= sh_cnt_reg[INDEX_W-1:0] - INDEX_W'(2);
        end

        // products
        for (int k = 0; k < 4; k++)
            mp_reg[k] <= weight_reg[k] * win_reg[k];
        mi_reg <= wi_reg;

        // sum
        acc_reg <= 38'(mp_reg[0]) + 38'(mp_reg[1]) + 38'(mp_reg[2]) + 38'(mp_reg[3]);
        ai_reg  <= mi_reg;

        // keep the values for the periodic boundary
        if (av_reg && ai_reg == INDEX_W'(1))
            fix1_reg <= sat_sample;
        if (av_reg && ai_reg == last_m1)
            fixm_reg <= sat_sample;
    end

endmodule
